### rtl/lsrl_pkg.sv
`default_nettype none
package lsrl_pkg;

  localparam int unsigned FreqW    = 32;
  localparam int unsigned RdivW    = 16;
  localparam int unsigned RcapW    = 48;
  localparam int unsigned LwW      = 17;
  localparam int unsigned TaskWW   = 14;
  localparam int unsigned RunW     = 48;
  localparam int unsigned ReqLenW  = 64;
  localparam int unsigned PrioW    = 6;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned Scale    = 100;
  localparam int unsigned ScaleW   = 7;

  localparam int unsigned LATENCY_LEVELS_DEF = 39;

  localparam logic [FreqW-1:0] FreqCapRst   = 32'd100000;
  localparam logic [RdivW-1:0] RdivRst      = 16'd2;
  localparam logic [RcapW-1:0] RcapRst      = 48'd50000000;
  localparam logic [LwW-1:0]   MaxLwRst     = 17'd10000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FREQ_CAP  = 2'd0,
    REG_RUN_DIV   = 2'd1,
    REG_RUN_CAP   = 2'd2,
    REG_MAX_LAT_W = 2'd3
  } cfg_reg_t;

  function automatic logic [LwW-1:0] nice_weight(input logic [PrioW-1:0] idx);
    logic [LwW-1:0] w;
    case (idx)
      6'd0:  w = 17'd88761;
      6'd1:  w = 17'd71755;
      6'd2:  w = 17'd56483;
      6'd3:  w = 17'd46273;
      6'd4:  w = 17'd36291;
      6'd5:  w = 17'd29154;
      6'd6:  w = 17'd23254;
      6'd7:  w = 17'd18705;
      6'd8:  w = 17'd14949;
      6'd9:  w = 17'd11916;
      6'd10: w = 17'd9548;
      6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;
      6'd13: w = 17'd4904;
      6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;
      6'd16: w = 17'd2501;
      6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;
      6'd19: w = 17'd1277;
      6'd20: w = 17'd1024;
      6'd21: w = 17'd820;
      6'd22: w = 17'd655;
      6'd23: w = 17'd526;
      6'd24: w = 17'd423;
      6'd25: w = 17'd335;
      6'd26: w = 17'd272;
      6'd27: w = 17'd215;
      6'd28: w = 17'd172;
      6'd29: w = 17'd137;
      6'd30: w = 17'd110;
      6'd31: w = 17'd87;
      6'd32: w = 17'd70;
      6'd33: w = 17'd56;
      6'd34: w = 17'd45;
      6'd35: w = 17'd36;
      6'd36: w = 17'd29;
      6'd37: w = 17'd23;
      6'd38: w = 17'd18;
      6'd39: w = 17'd15;
      default: w = 17'd15;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### rtl/lsrl_if.sv
`default_nettype none
interface lsrl_req_if;
  import lsrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [FreqW-1:0]  wake_rate;
  logic [FreqW-1:0]  block_rate;
  logic [TaskWW-1:0] task_weight;
  logic [RunW-1:0]   mean_run;
  modport source (output valid, wake_rate, block_rate, task_weight, mean_run,
                  input ready);
  modport sink   (input valid, wake_rate, block_rate, task_weight, mean_run,
                  output ready);
endinterface

interface lsrl_rsp_if;
  import lsrl_pkg::*;
  logic               valid;
  logic               ready;
  logic [ReqLenW-1:0] request_length;
  logic [PrioW-1:0]   latency_priority;
  modport source (output valid, request_length, latency_priority, input ready);
  modport sink   (input valid, request_length, latency_priority, output ready);
endinterface
`default_nettype wire

### rtl/lsrl_div.sv
`default_nettype none
// restoring divider, one quotient bit per stage
module lsrl_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               out_valid,
  output logic [NW-1:0]      quo,
  output logic [SW-1:0]      out_side
);

  logic [NW:0]   vld;
  logic [NW-1:0] nq  [NW+1];
  logic [DW-1:0] rm  [NW+1];
  logic [DW-1:0] dn  [NW+1];
  logic [SW-1:0] sd  [NW+1];

  assign vld[0] = in_valid;
  assign nq[0]  = num;
  assign rm[0]  = '0;
  assign dn[0]  = den;
  assign sd[0]  = side;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rm[i], nq[i][NW-1]};
    assign diff  = trial - {1'b0, dn[i]};
    assign ge    = trial >= {1'b0, dn[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq[i+1] <= {nq[i][NW-2:0], ge};
        dn[i+1] <= dn[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vld[NW];
  assign quo       = nq[NW];
  assign out_side  = sd[NW];

endmodule
`default_nettype wire

### rtl/latency_scaled_request_length.sv
`default_nettype none
// Throughput: one beat per cycle; the whole pipeline holds while the output is stalled.
// Depth is set by three bit-per-stage dividers (48, 55 and 55 stages).
// Reset: synchronous, clears valid bits and loads the register defaults.
module latency_scaled_request_length #(
  parameter int unsigned LATENCY_LEVELS = lsrl_pkg::LATENCY_LEVELS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [lsrl_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lsrl_pkg::CfgDataW-1:0] cfg_data,
  lsrl_req_if.sink                       req,
  lsrl_rsp_if.source                     rsp
);
  import lsrl_pkg::*;

  localparam logic [PrioW-1:0] PrioMax = PrioW'(LATENCY_LEVELS - 1);
  localparam int unsigned      ThrN    = LATENCY_LEVELS - 1;

  function automatic logic [PrioW-1:0] flog2(input logic [63:0] v);
    logic [PrioW-1:0] r;
    r = '0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) r = PrioW'(i);
    end
    return r;
  endfunction

  logic [FreqW-1:0] freq_cap;
  logic [RdivW-1:0] runtime_divisor;
  logic [RcapW-1:0] runtime_cap;
  logic [LwW-1:0]   max_latency_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_cap           <= FreqCapRst;
      runtime_divisor    <= RdivRst;
      runtime_cap        <= RcapRst;
      max_latency_weight <= MaxLwRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FREQ_CAP:  freq_cap           <= cfg_data[FreqW-1:0];
        REG_RUN_DIV:   runtime_divisor    <= cfg_data[RdivW-1:0];
        REG_RUN_CAP:   runtime_cap        <= cfg_data[RcapW-1:0];
        REG_MAX_LAT_W: max_latency_weight <= cfg_data[LwW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic d4_valid;
  assign en        = !d4_valid || rsp.ready;
  assign req.ready = en;

  // frequency product stages
  logic [6:1]        v;
  logic [FreqW-1:0]  s1_wf, s1_bf, s2_wf;
  logic [TaskWW-1:0] s1_w, s2_w, s3_w, s4_w, s5_w, s6_w;
  logic [RunW-1:0]   s1_avg, s2_avg, s3_avg, s4_avg, s5_avg, s6_avg;
  logic [63:0]       s2_p, s3_lo, s4_ff, s5_lo, s6_fw;
  logic [31:0]       s3_hi, s5_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wf  <= (req.wake_rate < freq_cap) ? req.wake_rate : freq_cap;
      s1_bf  <= (req.block_rate < freq_cap) ? req.block_rate : freq_cap;
      s1_w   <= req.task_weight;
      s1_avg <= req.mean_run;
      s2_p   <= 64'(s1_bf) * 64'(s1_wf);
      s2_wf  <= s1_wf;
      s2_w   <= s1_w;
      s2_avg <= s1_avg;
      s3_lo  <= 64'(s2_p[31:0]) * 64'(s2_wf);
      s3_hi  <= s2_p[63:32] * s2_wf;
      s3_w   <= s2_w;
      s3_avg <= s2_avg;
      s4_ff  <= s3_lo + {s3_hi, 32'd0};
      s4_w   <= s3_w;
      s4_avg <= s3_avg;
      s5_lo  <= 64'(s4_ff[31:0]) * 64'(s4_w);
      s5_hi  <= s4_ff[63:32] * 32'(s4_w);
      s5_w   <= s4_w;
      s5_avg <= s4_avg;
      s6_fw  <= s5_lo + {s5_hi, 32'd0};
      s6_w   <= s5_w;
      s6_avg <= s5_avg;
    end
  end

  // log2(fw / 100 + 1) >= k exactly when fw >= 100 * (2^k - 1)
  logic                   d1_valid;
  logic [ThrN-1:0]        d1_ge;
  logic [TaskWW+RunW-1:0] d1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else if (en) begin
      d1_valid <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ThrN; k++) begin
        d1_ge[k] <= s6_fw >= (64'(Scale) * ((64'd1 << (k + 1)) - 64'd1));
      end
      d1_side <= {s6_w, s6_avg};
    end
  end

  logic              s7_valid;
  logic [PrioW-1:0]  s7_prio;
  logic [TaskWW-1:0] s7_w;
  logic [RunW-1:0]   s7_avg;
  logic [PrioW-1:0]  d1_lg;

  always_comb begin
    d1_lg = '0;
    for (int k = 0; k < ThrN; k++) begin
      if (d1_ge[k]) begin
        d1_lg = PrioW'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_prio <= (d1_lg > PrioMax) ? PrioMax : d1_lg;
      s7_w    <= d1_side[TaskWW+RunW-1:RunW];
      s7_avg  <= d1_side[RunW-1:0];
    end
  end

  // runtime / divisor
  logic [RdivW-1:0] rdiv;
  assign rdiv = (runtime_divisor == '0) ? RdivW'(1) : runtime_divisor;

  logic                         d2_valid;
  logic [RunW-1:0]              d2_q;
  logic [PrioW+TaskWW+RunW-1:0] d2_side;

  lsrl_div #(.NW(RunW), .DW(RdivW), .SW(PrioW+TaskWW+RunW)) u_div_run (
    .clk, .rst, .en,
    .in_valid (s7_valid),
    .num      (s7_avg),
    .den      (rdiv),
    .side     ({s7_prio, s7_w, s7_avg}),
    .out_valid(d2_valid),
    .quo      (d2_q),
    .out_side (d2_side)
  );

  logic              s8_valid, s9_valid;
  logic [RunW-1:0]   s8_run;
  logic [PrioW-1:0]  s8_prio, s9_prio;
  logic [TaskWW-1:0] s8_w, s9_w;
  logic [RunW-1:0]   s8_avg, s9_avg;
  logic [54:0]       s9_run100;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
      s9_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= d2_valid;
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_run    <= (d2_q < runtime_cap) ? d2_q : runtime_cap;
      s8_prio   <= d2_side[PrioW+TaskWW+RunW-1:TaskWW+RunW];
      s8_w      <= d2_side[TaskWW+RunW-1:RunW];
      s8_avg    <= d2_side[RunW-1:0];
      s9_run100 <= 55'(s8_run) * 55'(Scale);
      s9_prio   <= s8_prio;
      s9_w      <= (s8_w == '0) ? TaskWW'(1) : s8_w;
      s9_avg    <= s8_avg;
    end
  end

  // scaled runtime / task weight
  logic                  d3_valid;
  logic [54:0]           d3_q;
  logic [PrioW+RunW-1:0] d3_side;

  lsrl_div #(.NW(55), .DW(TaskWW), .SW(PrioW+RunW)) u_div_pen (
    .clk, .rst, .en,
    .in_valid (s9_valid),
    .num      (s9_run100),
    .den      (s9_w),
    .side     ({s9_prio, s9_avg}),
    .out_valid(d3_valid),
    .quo      (d3_q),
    .out_side (d3_side)
  );

  logic [PrioW-1:0] pen, d3_prio;
  assign pen     = flog2(64'(d3_q) + 64'd1);
  assign d3_prio = d3_side[PrioW+RunW-1:RunW];

  logic             s10_valid, s11_valid;
  logic [PrioW-1:0] s10_prio, s11_prio;
  logic [RunW-1:0]  s10_avg;
  logic [LwW-1:0]   s11_lw, tab_w;
  logic [54:0]      s11_avg100;

  assign tab_w = nice_weight(PrioMax - s10_prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
      s11_valid <= 1'b0;
    end else if (en) begin
      s10_valid <= d3_valid;
      s11_valid <= s10_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_prio   <= (pen < d3_prio) ? d3_prio - pen : '0;
      s10_avg    <= d3_side[RunW-1:0];
      s11_prio   <= s10_prio;
      s11_avg100 <= 55'(s10_avg) * 55'(Scale);
      if (max_latency_weight == '0) begin
        s11_lw <= LwW'(1);
      end else begin
        s11_lw <= (tab_w < max_latency_weight) ? tab_w : max_latency_weight;
      end
    end
  end

  // request length = avg * 100 / latency weight
  logic [54:0]      d4_q;
  logic [PrioW-1:0] d4_prio;

  lsrl_div #(.NW(55), .DW(LwW), .SW(PrioW)) u_div_len (
    .clk, .rst, .en,
    .in_valid (s11_valid),
    .num      (s11_avg100),
    .den      (s11_lw),
    .side     (s11_prio),
    .out_valid(d4_valid),
    .quo      (d4_q),
    .out_side (d4_prio)
  );

  assign rsp.valid            = d4_valid;
  assign rsp.request_length   = ReqLenW'(d4_q);
  assign rsp.latency_priority = d4_prio;

endmodule
`default_nettype wire
